// ----- rtl/lsfs_pkg.sv -----
// Shared types and constants of the LED strip frame streamer.
`timescale 1ns / 1ps

package lsfs_pkg;

   // Colour bytes per LED and the slots of one LED record (brightness plus colours).
   localparam int BYTES_PER_LED = 3;
   localparam int SLOTS_PER_LED = BYTES_PER_LED + 1;

   // Marker bits above the five-bit brightness level.
   localparam logic [7:0] MARKER_BITS = 8'hE0;

   // Saturation value of the ready count.
   localparam logic [1:0] READY_MAX = 2'd2;

   // Input actions.
   localparam logic [1:0] ACT_NEXT  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // Frame part codes on the result channel.
   localparam logic [1:0] PART_START = 2'd0;
   localparam logic [1:0] PART_DATA  = 2'd1;
   localparam logic [1:0] PART_END   = 2'd2;

   typedef enum logic [1:0] {
      PH_START,
      PH_DATA,
      PH_END
   } phase_type;

   // Where the byte of a request comes from.
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_BRIGHT,
      KIND_STORE
   } kind_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] byte_address;
      logic [7:0] byte_value;
      logic [7:0] fill_first;
      logic [7:0] fill_second;
      logic [7:0] fill_third;
      logic       mark_ready;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] serial_byte;
      logic [1:0] frame_part;
      logic       frame_last;
   } rsp_payload_type;

   // What the frame cursor says about the next byte.
   typedef struct packed {
      logic       on;
      logic [1:0] part;
      logic       last;
      kind_type   kind;
   } cursor_type;

endpackage

// ----- rtl/lsfs_frame_cursor.sv -----
// Frame position, ready count and streaming flag of the LED strip frame streamer.
`timescale 1ns / 1ps

module lsfs_frame_cursor #(
   parameter int LED_COUNT = 32,
   parameter int PAD_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  raise,
   output lsfs_pkg::cursor_type  cur,
   output logic [$clog2(LED_COUNT * lsfs_pkg::BYTES_PER_LED)-1:0] rd_addr
);
   import lsfs_pkg::*;

   localparam int STORE_SIZE = LED_COUNT * BYTES_PER_LED;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int POS_MAX    = (STORE_SIZE > PAD_BYTES) ? STORE_SIZE : PAD_BYTES;
   localparam int POS_W      = $clog2(POS_MAX + 1);
   localparam logic [POS_W-1:0] POS_STORE = POS_W'(STORE_SIZE);
   localparam logic [POS_W-1:0] POS_PAD   = POS_W'(PAD_BYTES);
   localparam logic [1:0]       SLOT_LAST = 2'(SLOTS_PER_LED - 1);

   phase_type        phase_ff, phase_in, phase_nx;
   logic [POS_W-1:0] pos_ff, pos_in, pos_nx, pos_inc;
   logic [1:0]       slot_ff, slot_in, slot_nx;
   logic [1:0]       rc_ff, rc_in;
   logic             on_ff, on_in, on_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         slot_ff  <= '0;
         rc_ff    <= 2'd1;
         on_ff    <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         rc_ff    <= rc_in;
         on_ff    <= on_in;
      end
   end

   assign rd_addr = pos_ff[ADDR_W-1:0];

   always_comb begin
      pos_inc  = pos_ff + 1'b1;
      phase_nx = phase_ff;
      pos_nx   = pos_inc;
      slot_nx  = slot_ff;
      on_nx    = on_ff;
      cur.on   = on_ff;
      cur.part = PART_START;
      cur.last = 1'b0;
      cur.kind = KIND_ZERO;
      rc_in    = rc_ff;
      unique case (phase_ff)
         PH_DATA: begin
            cur.part = PART_DATA;
            if (slot_ff == 2'd0) begin
               cur.kind = KIND_BRIGHT;
               pos_nx   = pos_ff;
               slot_nx  = 2'd1;
            end else begin
               cur.kind = KIND_STORE;
               slot_nx  = (slot_ff == SLOT_LAST) ? 2'd0 : slot_ff + 2'd1;
            end
            if (pos_nx >= POS_STORE) begin
               phase_nx = PH_END;
               pos_nx   = '0;
               slot_nx  = 2'd0;
            end
         end
         PH_END: begin
            cur.part = PART_END;
            if (pos_inc >= POS_PAD) begin
               cur.last = 1'b1;
               phase_nx = PH_START;
               pos_nx   = '0;
               if (rc_ff == 2'd0) begin
                  on_nx = 1'b0;
               end
            end
         end
         default: begin
            if (pos_inc >= POS_PAD) begin
               phase_nx = PH_DATA;
               pos_nx   = '0;
               slot_nx  = 2'd0;
               if (step && rc_ff != 2'd0) begin
                  rc_in = rc_ff - 2'd1;
               end
            end
         end
      endcase

      phase_in = step ? phase_nx : phase_ff;
      pos_in   = step ? pos_nx   : pos_ff;
      slot_in  = step ? slot_nx  : slot_ff;
      on_in    = step ? on_nx    : on_ff;

      // A store change marked ready raises the count and restarts streaming.
      if (raise) begin
         if (rc_ff < READY_MAX) begin
            rc_in = rc_ff + 2'd1;
         end
         on_in = 1'b1;
      end
   end

endmodule

// ----- rtl/led_strip_frame_streamer.sv -----
// Top level of the LED strip frame streamer: colour store, sequencer and result register.
`timescale 1ns / 1ps

// Usage
// The req channel takes one word per action: a next-byte request, a single colour
// byte write, a fill of every LED with one colour, or a clear of the store. Each
// request made while streaming yields one rsp word: the serial byte, the frame part
// and a flag on the final byte of the end frame. Requests made while streaming is
// stopped yield nothing. The csr channel writes the five-bit brightness level and
// is always ready; write it only while the block is idle.
// The accepting edge of a request also reads its byte from the colour store, and
// the push step loads it into the rsp register once that register is free; only
// then is a new word accepted. A single byte write leaves the block ready for the
// next word. Fill and clear walk the store one byte a cycle, set by the single write
// port of the store. After reset the store is cleared by the same walk while
// req_ready stays low; csr writes are taken as usual.
// If the receiver stalls, the finished byte waits in the rsp register; one further
// word may be accepted and its byte is held until the register frees up.
module led_strip_frame_streamer #(
   parameter int LED_COUNT = 32,
   parameter int PAD_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lsfs_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lsfs_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [4:0]                 csr_data
);
   import lsfs_pkg::*;

   localparam int STORE_SIZE = LED_COUNT * BYTES_PER_LED;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);
   localparam logic [7:0]        STORE_SIZE_B = 8'(STORE_SIZE);

   // Control and configuration registers.
   state_type        state_ff, state_in;
   logic [4:0]       bright_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   // The byte being built for the pending request.
   kind_type         kind_ff, kind_in;
   logic [1:0]       part_ff, part_in;
   logic             last_ff, last_in;

   // Fill and clear walk over the store.
   logic [ADDR_W-1:0] sweep_ptr_ff, sweep_ptr_in;
   logic [1:0]        sweep_slot_ff, sweep_slot_in;
   logic [7:0]        fill_ff [BYTES_PER_LED];
   logic [7:0]        fill_in [BYTES_PER_LED];

   // Colour store.
   logic [7:0]        store_mem [STORE_SIZE];
   logic [7:0]        rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   // Frame cursor.
   cursor_type        cur;
   logic [ADDR_W-1:0] cur_addr;
   logic              cur_step, cur_raise;

   logic req_fire, out_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready   = 1'b1;

   lsfs_frame_cursor #(
      .LED_COUNT (LED_COUNT),
      .PAD_BYTES (PAD_BYTES)
   ) u_cursor (
      .clock   (clock),
      .reset   (reset),
      .step    (cur_step),
      .raise   (cur_raise),
      .cur     (cur),
      .rd_addr (cur_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         bright_ff     <= 5'd31;
         rsp_valid_ff  <= 1'b0;
         sweep_ptr_ff  <= '0;
         sweep_slot_ff <= '0;
         for (int i = 0; i < BYTES_PER_LED; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         sweep_slot_ff <= sweep_slot_in;
         fill_ff       <= fill_in;
         if (csr_valid && csr_ready) begin
            bright_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      kind_ff     <= kind_in;
      part_ff     <= part_in;
      last_ff     <= last_in;
   end

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[cur_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      kind_in       = kind_ff;
      part_in       = part_ff;
      last_in       = last_ff;
      sweep_ptr_in  = sweep_ptr_ff;
      sweep_slot_in = sweep_slot_ff;
      fill_in       = fill_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = sweep_ptr_ff;
      mem_wdata     = fill_ff[sweep_slot_ff];
      cur_step      = 1'b0;
      cur_raise     = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            if (sweep_ptr_ff == ADDR_LAST) begin
               sweep_ptr_in  = '0;
               sweep_slot_in = 2'd0;
               state_in      = ST_IDLE;
            end else begin
               sweep_ptr_in  = sweep_ptr_ff + 1'b1;
               sweep_slot_in = (sweep_slot_ff == 2'(BYTES_PER_LED - 1)) ?
                               2'd0 : sweep_slot_ff + 2'd1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.action)
                  ACT_NEXT: begin
                     if (cur.on) begin
                        cur_step = 1'b1;
                        mem_re   = (cur.kind == KIND_STORE);
                        kind_in  = cur.kind;
                        part_in  = cur.part;
                        last_in  = cur.last;
                        state_in = ST_PUSH;
                     end
                  end
                  ACT_WRITE: begin
                     cur_raise = req_payload.mark_ready;
                     if ({1'b0, req_payload.byte_address} < STORE_SIZE_B) begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(req_payload.byte_address);
                        mem_wdata = req_payload.byte_value;
                     end
                  end
                  ACT_FILL: begin
                     cur_raise  = req_payload.mark_ready;
                     fill_in[0] = req_payload.fill_first;
                     fill_in[1] = req_payload.fill_second;
                     fill_in[2] = req_payload.fill_third;
                     state_in   = ST_SWEEP;
                  end
                  default: begin
                     cur_raise = req_payload.mark_ready;
                     for (int i = 0; i < BYTES_PER_LED; i++) begin
                        fill_in[i] = '0;
                     end
                     state_in = ST_SWEEP;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.frame_part = part_ff;
               rsp_data_in.frame_last = last_ff;
               unique case (kind_ff)
                  KIND_BRIGHT: rsp_data_in.serial_byte = MARKER_BITS | {3'b000, bright_ff};
                  KIND_STORE:  rsp_data_in.serial_byte = rdata_ff;
                  default:     rsp_data_in.serial_byte = 8'h00;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A new result can only come out of the push step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUSH))
      else $error("result appeared without a push step");

   // The store is never written and read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("colour store written and read together");

   // The final-byte flag belongs to the end frame only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.frame_last || rsp_data_ff.frame_part == PART_END))
      else $error("frame_last outside the end frame");

   // A push step follows an accepted request or a stalled push.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> ($past(state_ff == ST_IDLE) || $past(state_ff == ST_PUSH)))
      else $error("push step entered from the wrong state");

   // A stalled result word is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("stalled result changed");

endmodule

// ----- verif/led_strip_frame_streamer_test.sv -----
// Self-checking testbench for the LED strip frame streamer: predicted byte stream versus the rsp channel.
`timescale 1ns / 1ps

module led_strip_frame_streamer_test;
   import lsfs_pkg::*;

   localparam int LEDS = 32;
   localparam int PAD = 8;
   localparam int STORE_BYTES = LEDS * BYTES_PER_LED;
   // Fill and clear walk the whole store, so this covers any write still in flight
   // after the last result, with room for the request turnaround.
   localparam int SETTLE_CYCLES = STORE_BYTES + 32;
   // Longest legal quiet stretch is the settle pause plus a fill; this is many times that.
   localparam int QUIET_LIMIT = 4000;

   // The driver works through a list of steps: words for the req channel, brightness
   // writes, pauses that wait for every predicted byte, and changes of idling pattern.
   typedef enum {
      STEP_WORD,
      STEP_CSR,
      STEP_SETTLE,
      STEP_IDLING
   } step_kind_type;

   typedef struct {
      step_kind_type   kind;
      req_payload_type word;
      logic [4:0]      level;
      int              hold;
      int              send_pct;
      int              recv_pct;
   } step_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [4:0]      csr_data = '0;

   step_type        pending_steps[$];
   rsp_payload_type awaited_words[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              failures = 0;
   // Words that did something: store changes and requests made while streaming.
   int              effective_items = 0;

   // Shadow of the block's state, advanced once per accepted word.
   logic [7:0]      colour_bytes [STORE_BYTES];
   phase_type       frame_phase_now = PH_START;
   int              byte_cursor = 0;
   int              led_slot = 0;
   logic [1:0]      ready_credit = 2'd1;
   bit              stream_on = 1'b1;
   logic [4:0]      level_now = 5'd31;

   led_strip_frame_streamer #(
      .LED_COUNT(LEDS),
      .PAD_BYTES(PAD)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the shadow by one accepted word and queues the byte it should produce.
   // Store changes produce nothing; a request while stopped is dropped without a trace.
   function automatic void step_led_frame(req_payload_type w);
      rsp_payload_type r;
      r = '0;
      if (w.action != ACT_NEXT) begin
         effective_items++;
         case (w.action)
            ACT_WRITE: begin
               // Addresses past the last LED are ignored, but mark_ready still counts.
               if (w.byte_address < STORE_BYTES) colour_bytes[w.byte_address] = w.byte_value;
            end
            ACT_FILL: begin
               for (int i = 0; i < STORE_BYTES; i++) begin
                  case (i % BYTES_PER_LED)
                     0: colour_bytes[i] = w.fill_first;
                     1: colour_bytes[i] = w.fill_second;
                     default: colour_bytes[i] = w.fill_third;
                  endcase
               end
            end
            default: begin
               for (int i = 0; i < STORE_BYTES; i++) colour_bytes[i] = 8'h00;
            end
         endcase
         if (w.mark_ready) begin
            if (ready_credit < READY_MAX) ready_credit++;
            stream_on = 1'b1;
         end
         return;
      end
      if (!stream_on) return;
      effective_items++;
      case (frame_phase_now)
         PH_DATA: begin
            // Each LED is a brightness word followed by its colour bytes in store order.
            r.frame_part = PART_DATA;
            led_slot++;
            if (led_slot == 1) begin
               r.serial_byte = MARKER_BITS | {3'b000, level_now};
            end else begin
               if (byte_cursor < STORE_BYTES) r.serial_byte = colour_bytes[byte_cursor];
               byte_cursor++;
               if (led_slot >= SLOTS_PER_LED) led_slot = 0;
            end
            if (byte_cursor >= STORE_BYTES) begin
               frame_phase_now = PH_END;
               byte_cursor = 0;
               led_slot = 0;
            end
         end
         PH_END: begin
            r.frame_part = PART_END;
            byte_cursor++;
            if (byte_cursor >= PAD) begin
               // Streaming halts here when no fresh data has been marked.
               r.frame_last = 1'b1;
               frame_phase_now = PH_START;
               byte_cursor = 0;
               if (ready_credit == 2'd0) stream_on = 1'b0;
            end
         end
         default: begin
            r.frame_part = PART_START;
            byte_cursor++;
            if (byte_cursor >= PAD) begin
               frame_phase_now = PH_DATA;
               byte_cursor = 0;
               led_slot = 0;
               if (ready_credit > 2'd0) ready_credit--;
            end
         end
      endcase
      awaited_words.push_back(r);
   endfunction

   // Every field random; addresses stray past the store one time in eight.
   function automatic req_payload_type random_word(logic [1:0] act);
      req_payload_type w;
      w.action = act;
      if ($urandom_range(7) == 0) w.byte_address = 7'($urandom_range(127, STORE_BYTES));
      else w.byte_address = 7'($urandom_range(STORE_BYTES - 1));
      w.byte_value = 8'($urandom);
      w.fill_first = 8'($urandom);
      w.fill_second = 8'($urandom);
      w.fill_third = 8'($urandom);
      w.mark_ready = 1'($urandom);
      return w;
   endfunction

   task automatic queue_word(req_payload_type w);
      step_type s;
      s = '{kind: STEP_WORD, word: w, level: '0, hold: 0, send_pct: 0, recv_pct: 0};
      pending_steps.push_back(s);
   endtask

   task automatic queue_write(logic [6:0] addr, logic [7:0] value, logic mark);
      req_payload_type w;
      w = random_word(ACT_WRITE);
      w.byte_address = addr;
      w.byte_value = value;
      w.mark_ready = mark;
      queue_word(w);
   endtask

   task automatic queue_requests(int count);
      repeat (count) queue_word(random_word(ACT_NEXT));
   endtask

   task automatic queue_settle(int hold);
      step_type s;
      s = '{kind: STEP_SETTLE, word: '0, level: '0, hold: hold, send_pct: 0, recv_pct: 0};
      pending_steps.push_back(s);
   endtask

   task automatic queue_csr(logic [4:0] level);
      step_type s;
      s = '{kind: STEP_CSR, word: '0, level: level, hold: 0, send_pct: 0, recv_pct: 0};
      pending_steps.push_back(s);
   endtask

   task automatic queue_idling(int send_pct, int recv_pct);
      step_type s;
      s = '{kind: STEP_IDLING, word: '0, level: '0, hold: 0,
            send_pct: send_pct, recv_pct: recv_pct};
      pending_steps.push_back(s);
   endtask

   // One stretch of mostly requests with store changes mixed in. Data is marked ready
   // only in a few stretches, so the ready count runs dry and the stream stops at the
   // end of a frame. A stopped stream gets a few requests (dropped) and then a marked
   // store change that restarts it from the first start-frame byte.
   task automatic queue_batch();
      req_payload_type w;
      int              roll;
      bit              marks;
      marks = ($urandom_range(4) == 0);
      if (!stream_on) begin
         queue_requests($urandom_range(4, 1));
         roll = $urandom_range(3);
         w = random_word(roll == 0 ? ACT_FILL : (roll == 1 ? ACT_CLEAR : ACT_WRITE));
         w.mark_ready = 1'b1;
         queue_word(w);
      end
      repeat ($urandom_range(40, 12)) begin
         roll = $urandom_range(99);
         if (roll < 80) w = random_word(ACT_NEXT);
         else if (roll < 93) w = random_word(ACT_WRITE);
         else if (roll < 97) w = random_word(ACT_FILL);
         else w = random_word(ACT_CLEAR);
         if (w.action != ACT_NEXT) w.mark_ready = marks && ($urandom_range(2) == 0);
         queue_word(w);
      end
      // Now and then hold the sender back until the stream has fully drained.
      if ($urandom_range(7) == 0) queue_settle(0);
   endtask

   // Driver: takes one step per edge while no pause or busy channel holds it. Words go out
   // back to back when the channel is free; a brightness write waits until no word is in flight,
   // and no word follows a brightness write in the same cycle, so the two never share an edge.
   always @(posedge clock) begin : feed
      step_type head;
      logic     word_live;
      logic     csr_live;
      logic     next_req_valid;
      logic     next_csr_valid;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         hold_left = 0;
      end else begin
         word_live = req_valid && !req_ready;
         csr_live = csr_valid && !csr_ready;
         next_req_valid = word_live;
         next_csr_valid = csr_live;
         if (hold_left > 0) begin
            hold_left--;
         end else if (pending_steps.size() > 0 && !word_live && !csr_valid) begin
            head = pending_steps[0];
            case (head.kind)
               STEP_WORD: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     void'(pending_steps.pop_front());
                     req_payload <= head.word;
                     next_req_valid = 1'b1;
                  end
               end
               STEP_CSR: begin
                  if (!req_valid) begin
                     void'(pending_steps.pop_front());
                     csr_data <= head.level;
                     next_csr_valid = 1'b1;
                  end
               end
               STEP_SETTLE: begin
                  // The word accepted last must have been predicted before the check.
                  if (!req_valid && awaited_words.size() == 0) begin
                     void'(pending_steps.pop_front());
                     hold_left = head.hold;
                  end
               end
               default: begin
                  void'(pending_steps.pop_front());
                  send_idle_pct = head.send_pct;
                  recv_idle_pct = head.recv_pct;
               end
            endcase
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: updates the shadow on every accepted word and brightness write, and
   // checks each accepted result against the oldest predicted byte.
   always @(posedge clock) begin : check
      rsp_payload_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) level_now = csr_data;
         if (req_valid && req_ready) step_led_frame(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_payload);
               failures++;
            end else begin
               want = awaited_words.pop_front();
               if (rsp_payload.serial_byte !== want.serial_byte) begin
                  $display("%0t: serial_byte expected %h, got %h",
                           $time, want.serial_byte, rsp_payload.serial_byte);
                  failures++;
               end
               if (rsp_payload.frame_part !== want.frame_part) begin
                  $display("%0t: frame_part expected %0d, got %0d",
                           $time, want.frame_part, rsp_payload.frame_part);
                  failures++;
               end
               if (rsp_payload.frame_last !== want.frame_last) begin
                  $display("%0t: frame_last expected %b, got %b",
                           $time, want.frame_last, rsp_payload.frame_last);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog: a run that stops accepting anything on any channel has hung.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_payload_type w;
      int              phase_goal;
      for (int i = 0; i < STORE_BYTES; i++) colour_bytes[i] = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. The block may still be clearing its store; the csr port
      // takes writes regardless, and words wait on req_ready.
      queue_idling(14, 47);
      queue_csr(5'd5);
      // A request carrying mark_ready: the mark must be ignored.
      w = random_word(ACT_NEXT);
      w.mark_ready = 1'b1;
      queue_word(w);
      // Both ends of the store, then two addresses past it; the first of those
      // still marks data ready.
      queue_write(7'd0, 8'hFF, 1'b0);
      queue_write(7'(STORE_BYTES - 1), 8'h80, 1'b0);
      queue_write(7'(STORE_BYTES), 8'h11, 1'b1);
      queue_write(7'd127, 8'h7F, 1'b0);
      // Rest of the start frame, the first brightness word and the first colour.
      queue_requests(9);
      // Fill and clear in the middle of an LED take effect for bytes not yet sent.
      w = random_word(ACT_FILL);
      w.fill_first = 8'hAA;
      w.fill_second = 8'h55;
      w.fill_third = 8'h0F;
      w.mark_ready = 1'b0;
      queue_word(w);
      queue_requests(1);
      w = random_word(ACT_CLEAR);
      w.mark_ready = 1'b0;
      queue_word(w);
      queue_requests(1);
      queue_write(7'd4, 8'hC3, 1'b0);
      queue_requests(3);
      w = random_word(ACT_CLEAR);
      w.mark_ready = 1'b1;
      queue_word(w);
      queue_requests(1);
      // Let everything drain before the random part.
      queue_settle(0);

      // Three random phases: sender idles lightly and receiver heavily, then the
      // reverse, then neither. Brightness changes only in the settled gap between.
      for (int p = 0; p < 3; p++) begin
         queue_settle(SETTLE_CYCLES);
         queue_csr(p == 0 ? 5'd0 : (p == 1 ? 5'd31 : 5'($urandom)));
         queue_idling(p == 0 ? 14 : (p == 1 ? 47 : 0), p == 0 ? 47 : (p == 1 ? 14 : 0));
         phase_goal = effective_items + 134;
         while (effective_items < phase_goal) begin
            while (pending_steps.size() >= 4) @(negedge clock);
            queue_batch();
         end
      end

      while (pending_steps.size() > 0 || req_valid) @(negedge clock);
      while (awaited_words.size() > 0) @(negedge clock);
      // A last fill or clear may still be walking the store; any stray word shows here.
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (awaited_words.size() > 0) begin
         $display("%0t: %0d expected words never arrived", $time, awaited_words.size());
         failures++;
      end
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lsfs_pkg.sv
rtl/lsfs_frame_cursor.sv
rtl/led_strip_frame_streamer.sv
verif/led_strip_frame_streamer_test.sv
